// ===== sv/cpf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and command/status types for the colour projection features unit.
package cpf_pkg;

	localparam int CPF_IMAGE_SIDE = 24;
	localparam int CPF_PIX_W      = 8;
	localparam int CPF_IDX_W      = 6;
	localparam int CPF_RATIO_W    = 17;
	localparam int CPF_NUM_RATIOS = 6;

	localparam logic [1:0] KIND_ROWCOL = 2'd0;
	localparam logic [1:0] KIND_WHOLE  = 2'd1;
	localparam logic [1:0] KIND_QUAD   = 2'd2;

	typedef struct packed {
		logic                 accept;
		logic                 accum;
		logic                 rd;
		logic                 load;
		logic                 store;
		logic                 clear;
		logic [CPF_IDX_W-1:0] grp;
		logic [2:0]           sel;
	} cpf_cmd_t;

	typedef struct packed {
		logic last_px;
		logic div_done;
	} cpf_stat_t;

endpackage

// ===== sv/colour_projection_features_unit.sv =====
`timescale 1ns / 1ps
// Top level of the colour projection features unit.
// Takes an IMAGE_SIDE by IMAGE_SIDE image one pixel item at a time in raster order; each
// pixel passes an accept state and an accumulate state, for the read-modify-write of the
// column-sum memory. After the last pixel the block stops taking items and emits
// IMAGE_SIDE + 5 result items through a single 17-step divider, 6 * IMAGE_SIDE + 15
// divisions in all: each group has a read state, then a load and a divide state per
// ratio, then an output state that holds while out_stall is high. Zero denominators give
// ratio 0 and set zero_divisor; all sums clear after the item marked last, and no clearing
// pass is needed after reset.
module colour_projection_features_unit import cpf_pkg::*; #(
	parameter int IMAGE_SIDE = CPF_IMAGE_SIDE
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [CPF_PIX_W-1:0]   red,
	input  logic [CPF_PIX_W-1:0]   green,
	input  logic [CPF_PIX_W-1:0]   blue,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             group_kind,
	output logic [CPF_IDX_W-1:0]   group_index,
	output logic [CPF_RATIO_W-1:0] ratio_a,
	output logic [CPF_RATIO_W-1:0] ratio_b,
	output logic [CPF_RATIO_W-1:0] ratio_c,
	output logic [CPF_RATIO_W-1:0] ratio_d,
	output logic [CPF_RATIO_W-1:0] ratio_e,
	output logic [CPF_RATIO_W-1:0] ratio_f,
	output logic                   zero_divisor,
	output logic                   last
);

	cpf_cmd_t  cmd;
	cpf_stat_t stat;

	cpf_ctrl #(.IMAGE_SIDE(IMAGE_SIDE)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	cpf_datapath #(.IMAGE_SIDE(IMAGE_SIDE)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.group_kind   (group_kind),
		.group_index  (group_index),
		.ratio_a      (ratio_a),
		.ratio_b      (ratio_b),
		.ratio_c      (ratio_c),
		.ratio_d      (ratio_d),
		.ratio_e      (ratio_e),
		.ratio_f      (ratio_f),
		.zero_divisor (zero_divisor),
		.last         (last)
	);

endmodule

// ===== sv/cpf_div.sv =====
`timescale 1ns / 1ps
// Restoring divider giving a 17-bit Q1.16 share, one quotient bit per cycle.
module cpf_div import cpf_pkg::*; #(
	parameter int DW = 21
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [DW-1:0]          num,
	input  logic [DW-1:0]          den,
	output logic                   done,
	output logic [CPF_RATIO_W-1:0] quot,
	output logic                   den_zero
);

	logic [DW:0]            rem_q;
	logic [DW-1:0]          den_q;
	logic [CPF_RATIO_W-1:0] quot_q;
	logic [4:0]             cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [DW:0]            cand;
	logic                   ge;

	// first step compares the numerator itself, later steps the doubled remainder
	assign cand = (cnt_q == 5'd0) ? rem_q : {rem_q[DW-1:0], 1'b0};
	assign ge   = cand >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(CPF_RATIO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (cand - {1'b0, den_q}) : cand;
			quot_q <= {quot_q[CPF_RATIO_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign den_zero = (den_q == '0);
	assign quot     = den_zero ? '0 : quot_q;

endmodule

// ===== sv/cpf_datapath.sv =====
`timescale 1ns / 1ps
// Sum stores, operand selection, shared divider and result registers.
module cpf_datapath import cpf_pkg::*; #(
	parameter int IMAGE_SIDE = CPF_IMAGE_SIDE
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cpf_cmd_t               cmd,
	output cpf_stat_t              stat,
	input  logic [CPF_PIX_W-1:0]   red,
	input  logic [CPF_PIX_W-1:0]   green,
	input  logic [CPF_PIX_W-1:0]   blue,
	output logic [1:0]             group_kind,
	output logic [CPF_IDX_W-1:0]   group_index,
	output logic [CPF_RATIO_W-1:0] ratio_a,
	output logic [CPF_RATIO_W-1:0] ratio_b,
	output logic [CPF_RATIO_W-1:0] ratio_c,
	output logic [CPF_RATIO_W-1:0] ratio_d,
	output logic [CPF_RATIO_W-1:0] ratio_e,
	output logic [CPF_RATIO_W-1:0] ratio_f,
	output logic                   zero_divisor,
	output logic                   last
);

	localparam int IW = $clog2(IMAGE_SIDE);
	localparam int RW = $clog2(IMAGE_SIDE * 255 + 1);
	localparam int TW = $clog2(IMAGE_SIDE * IMAGE_SIDE * 255 + 1);
	localparam int DW = $clog2(3 * IMAGE_SIDE * IMAGE_SIDE * 255 + 1);
	localparam logic [IW-1:0] SIDE_END = IW'(IMAGE_SIDE - 1);
	localparam logic [IW-1:0] HALF     = IW'(IMAGE_SIDE / 2);
	localparam logic [CPF_IDX_W-1:0] G_SIDE  = CPF_IDX_W'(IMAGE_SIDE);
	localparam logic [CPF_IDX_W-1:0] G_QUAD0 = CPF_IDX_W'(IMAGE_SIDE + 1);
	localparam logic [CPF_IDX_W-1:0] G_LAST  = CPF_IDX_W'(IMAGE_SIDE + 4);

	logic [3*RW-1:0] row_mem [IMAGE_SIDE];
	logic [3*RW-1:0] col_mem [IMAGE_SIDE];
	logic [3*RW-1:0] row_rd_q;
	logic [3*RW-1:0] col_rd_q;
	logic [CPF_PIX_W-1:0] pix_q [3];
	logic [RW-1:0]   racc_q [3];
	logic [TW-1:0]   tot_q [3];
	logic [TW-1:0]   quad_q [3][4];
	logic [IW-1:0]   row_q;
	logic [IW-1:0]   col_q;
	logic [CPF_RATIO_W-1:0] ratio_q [CPF_NUM_RATIOS];
	logic            zero_q;
	logic [1:0]      kind_q;
	logic [CPF_IDX_W-1:0] index_q;
	logic            last_q;

	logic [RW-1:0]   row_new [3];
	logic [RW-1:0]   col_new [3];
	logic [3*RW-1:0] row_word;
	logic [3*RW-1:0] col_word;
	logic [1:0]      pq;
	logic [IW-1:0]   rd_addr;
	logic [1:0]      kind;
	logic [CPF_IDX_W-1:0] qoff;
	logic [1:0]      qi;
	logic [2:0]      chx;
	logic [1:0]      ch;
	logic [DW-1:0]   num;
	logic [DW-1:0]   den;
	logic [DW-1:0]   all_sum;
	logic [DW-1:0]   quad_sum;
	logic            div_done;
	logic [CPF_RATIO_W-1:0] quot;
	logic            den_zero;

	assign pq = {row_q >= HALF, col_q >= HALF};

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			row_new[c] = ((col_q == '0) ? '0 : racc_q[c]) + RW'(pix_q[c]);
			// first row starts the column sums afresh
			col_new[c] = ((row_q == '0) ? '0 : col_rd_q[c*RW +: RW]) + RW'(pix_q[c]);
			row_word[c*RW +: RW] = row_new[c];
			col_word[c*RW +: RW] = col_new[c];
		end
	end

	assign rd_addr = cmd.rd ? cmd.grp[IW-1:0] : col_q;

	always_ff @(posedge clk) begin
		if (cmd.accept || cmd.rd) begin
			col_rd_q <= col_mem[rd_addr];
			row_rd_q <= row_mem[rd_addr];
		end
		if (cmd.accum) begin
			col_mem[col_q] <= col_word;
			if (col_q == SIDE_END) begin
				row_mem[row_q] <= row_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q[0] <= red;
			pix_q[1] <= green;
			pix_q[2] <= blue;
		end
		if (cmd.accum) begin
			for (int c = 0; c < 3; c++) begin
				racc_q[c] <= row_new[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			for (int c = 0; c < 3; c++) begin
				tot_q[c] <= '0;
				for (int q = 0; q < 4; q++) begin
					quad_q[c][q] <= '0;
				end
			end
		end else if (cmd.clear) begin
			row_q <= '0;
			col_q <= '0;
			for (int c = 0; c < 3; c++) begin
				tot_q[c] <= '0;
				for (int q = 0; q < 4; q++) begin
					quad_q[c][q] <= '0;
				end
			end
		end else if (cmd.accum) begin
			for (int c = 0; c < 3; c++) begin
				tot_q[c]      <= tot_q[c] + TW'(pix_q[c]);
				quad_q[c][pq] <= quad_q[c][pq] + TW'(pix_q[c]);
			end
			if (col_q == SIDE_END) begin
				col_q <= '0;
				row_q <= (row_q == SIDE_END) ? '0 : row_q + IW'(1);
			end else begin
				col_q <= col_q + IW'(1);
			end
		end
	end

	assign stat.last_px  = (row_q == SIDE_END) && (col_q == SIDE_END);
	assign stat.div_done = div_done;

	always_comb begin
		if (cmd.grp < G_SIDE) begin
			kind = KIND_ROWCOL;
		end else if (cmd.grp == G_SIDE) begin
			kind = KIND_WHOLE;
		end else begin
			kind = KIND_QUAD;
		end
	end

	assign qoff     = cmd.grp - G_QUAD0;
	assign qi       = qoff[1:0];
	assign chx      = (cmd.sel >= 3'd3) ? cmd.sel - 3'd3 : cmd.sel;
	assign ch       = chx[1:0];
	assign all_sum  = DW'(tot_q[0]) + DW'(tot_q[1]) + DW'(tot_q[2]);
	assign quad_sum = DW'(quad_q[0][qi]) + DW'(quad_q[1][qi]) + DW'(quad_q[2][qi]);

	always_comb begin
		num = '0;
		den = '0;
		unique case (kind)
			KIND_ROWCOL: begin
				num = (cmd.sel >= 3'd3) ? DW'(col_rd_q[ch*RW +: RW])
				                        : DW'(row_rd_q[ch*RW +: RW]);
				den = DW'(tot_q[ch]);
			end
			KIND_WHOLE: begin
				num = DW'(tot_q[ch]);
				den = all_sum;
			end
			KIND_QUAD: begin
				num = DW'(quad_q[ch][qi]);
				den = quad_sum;
			end
			default: begin
				num = '0;
				den = '0;
			end
		endcase
	end

	cpf_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.load),
		.num      (num),
		.den      (den),
		.done     (div_done),
		.quot     (quot),
		.den_zero (den_zero)
	);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			for (int j = 0; j < CPF_NUM_RATIOS; j++) begin
				ratio_q[j] <= '0;
			end
			zero_q  <= 1'b0;
			kind_q  <= kind;
			index_q <= (kind == KIND_ROWCOL) ? cmd.grp
			         : (kind == KIND_QUAD) ? CPF_IDX_W'(qi) : '0;
			last_q  <= (cmd.grp == G_LAST);
		end else if (cmd.store) begin
			ratio_q[cmd.sel] <= quot;
			zero_q           <= zero_q | den_zero;
		end
	end

	assign group_kind   = kind_q;
	assign group_index  = index_q;
	assign ratio_a      = ratio_q[0];
	assign ratio_b      = ratio_q[1];
	assign ratio_c      = ratio_q[2];
	assign ratio_d      = ratio_q[3];
	assign ratio_e      = ratio_q[4];
	assign ratio_f      = ratio_q[5];
	assign zero_divisor = zero_q;
	assign last         = last_q;

endmodule

// ===== sv/cpf_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: pixel accumulation, then division and output of every result group.
module cpf_ctrl import cpf_pkg::*; #(
	parameter int IMAGE_SIDE = CPF_IMAGE_SIDE
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output cpf_cmd_t  cmd,
	input  cpf_stat_t stat
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ACC  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_LOAD = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;
	localparam logic [CPF_IDX_W-1:0] G_SIDE = CPF_IDX_W'(IMAGE_SIDE);
	localparam logic [CPF_IDX_W-1:0] G_LAST = CPF_IDX_W'(IMAGE_SIDE + 4);

	logic [2:0]           state_q;
	logic [CPF_IDX_W-1:0] grp_q;
	logic [2:0]           sel_q;
	logic [2:0]           sel_end;
	logic                 out_go;

	assign sel_end = (grp_q < G_SIDE) ? 3'd5 : 3'd2;
	assign out_go  = (state_q == S_OUT) && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			grp_q   <= '0;
			sel_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (stat.last_px) begin
						grp_q   <= '0;
						state_q <= S_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					sel_q   <= '0;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (stat.div_done) begin
						if (sel_q == sel_end) begin
							state_q <= S_OUT;
						end else begin
							sel_q   <= sel_q + 3'd1;
							state_q <= S_LOAD;
						end
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						if (grp_q == G_LAST) begin
							grp_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							grp_q   <= grp_q + CPF_IDX_W'(1);
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.accum  = (state_q == S_ACC);
		cmd.rd     = (state_q == S_RD);
		cmd.load   = (state_q == S_LOAD);
		cmd.store  = (state_q == S_DIV) && stat.div_done;
		// drop the sums once the final group has gone
		cmd.clear  = out_go && (grp_q == G_LAST);
		cmd.grp    = grp_q;
		cmd.sel    = sel_q;
	end

endmodule
